[rtl/core/spq_pkg.sv]
package spq_pkg;

    // Default number of entries held by the queue.
    localparam int unsigned CAPACITY_DEF = 16;

    localparam int unsigned PRIO_W   = 16;
    localparam int unsigned ITEM_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 5;

    // Operation codes carried on the input channel.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // One queue entry as it moves along the chain.
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [ITEM_W-1:0]        item;
    } entry_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic   insert_en;
        logic   pop_en;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

[rtl/core/spq_cell.sv]
module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned INDEX   = 0,
    parameter int unsigned COUNT_W = 5
) (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic [COUNT_W-1:0] count,
    input  logic               left_keep,
    input  entry_t             left_entry,
    input  entry_t             right_entry,
    output logic               keep,
    output entry_t             entry
);

    localparam logic [COUNT_W-1:0] IDX = COUNT_W'(INDEX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    // A cell is occupied when its position lies below the fill count.
    assign occupied = (count > IDX);

    // The cell stays in place when its entry ranks at or above the newcomer,
    // which keeps equal priorities in arrival order.
    assign keep = occupied && (entry_reg.prio >= ctrl.new_entry.prio);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.pop_en) begin
            entry_next = right_entry;
        end else if (ctrl.insert_en && !keep) begin
            if (left_keep) begin
                entry_next = ctrl.new_entry;
            end else begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[rtl/core/stable_priority_queue.sv]
// Channel | Direction | Ports                                        | Handshake
// s_      | in        | opcode, item_handle, priority_req            | s_valid / s_ready
// m_      | out       | status, popped_item, popped_priority, occup. | m_valid / m_ready
//
// Each transfer on the input channel yields one result in the output register on the
// following edge; one operation per cycle is sustained while m_ready stays high.
// The per-cell compare against the new priority sets the cycle time.
// aresetn is synchronous and active low; it empties the queue and the output register.
// s_ready drops only while a result waits in the output register and m_ready is low.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [ITEM_W-1:0]        s_item_handle,
    input  logic signed [PRIO_W-1:0] s_priority_req,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [ITEM_W-1:0]        m_popped_item,
    output logic signed [PRIO_W-1:0] m_popped_priority,
    output logic [OCC_W-1:0]         m_occupancy
);

    localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    // Fill count of the chain; only cells below it hold live entries.
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Output register: control part is reset, payload part is not.
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [ITEM_W-1:0]        popped_item_reg;
    logic [ITEM_W-1:0]        popped_item_next;
    logic signed [PRIO_W-1:0] popped_prio_reg;
    logic signed [PRIO_W-1:0] popped_prio_next;
    logic [OCC_W-1:0]         occupancy_reg;
    logic [OCC_W-1:0]         occupancy_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    // Chain wiring: each cell sees its left and right neighbor.
    entry_t cell_entry [CAPACITY];
    logic   cell_keep  [CAPACITY];

    // A new transfer is taken whenever the output register is free or is being
    // emptied in this same cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    always_comb begin
        ctrl.insert_en      = accept && (s_opcode == OP_INSERT) && !is_full;
        ctrl.pop_en         = accept && (s_opcode == OP_POP) && !is_empty;
        ctrl.new_entry.prio = s_priority_req;
        ctrl.new_entry.item = s_item_handle;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic   left_keep;
            entry_t left_entry;
            entry_t right_entry;

            if (gi == 0) begin : g_head
                // The head has nothing in front of it, so a newcomer that does
                // not rank behind it lands here.
                assign left_keep  = 1'b1;
                assign left_entry = '0;
            end else begin : g_body
                assign left_keep  = cell_keep[gi-1];
                assign left_entry = cell_entry[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_entry = '0;
            end else begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end

            spq_cell #(
                .INDEX   (gi),
                .COUNT_W (COUNT_W)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .left_keep   (left_keep),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .keep        (cell_keep[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    // Next count, valid flag, status, popped fields and occupancy for the transfer being taken.
    always_comb begin
        count_next       = count_reg;
        status_next      = status_reg;
        popped_item_next = popped_item_reg;
        popped_prio_next = popped_prio_reg;
        m_valid_next     = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next     = 1'b1;
            popped_item_next = '0;
            popped_prio_next = '0;
            if (s_opcode == OP_INSERT) begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + COUNT_W'(1);
                end
            end else begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    status_next      = ST_POPPED;
                    popped_item_next = cell_entry[0].item;
                    popped_prio_next = cell_entry[0].prio;
                    count_next       = count_reg - COUNT_W'(1);
                end
            end
        end

        // The occupancy field is five bits wide and wraps for larger queues.
        occupancy_next = OCC_W'(count_next);
        if (!accept) begin
            occupancy_next = occupancy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg      <= status_next;
        popped_item_reg <= popped_item_next;
        popped_prio_reg <= popped_prio_next;
        occupancy_reg   <= occupancy_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_popped_item     = popped_item_reg;
    assign m_popped_priority = popped_prio_reg;
    assign m_occupancy       = occupancy_reg;

endmodule

[rtl/core/spq_checker.sv]
module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [STATUS_W-1:0]      m_status,
    input logic [ITEM_W-1:0]        m_popped_item,
    input logic signed [PRIO_W-1:0] m_popped_priority,
    input logic [OCC_W-1:0]         m_occupancy
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_popped_item)
            && $stable(m_popped_priority) && $stable(m_occupancy))
        else $error("result changed while stalled");

    // Input is only held off by a pending, untaken result.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a pending result");

    // Only a pop carries a handle and a priority.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_POPPED) |-> (m_popped_item == '0)
            && (m_popped_priority == '0))
        else $error("nonzero popped fields on a non-pop result");

    // A pop on empty leaves nothing behind.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> (m_occupancy == '0))
        else $error("pop on empty with nonzero occupancy");

    // A dropped insert means the queue is at capacity.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> (m_occupancy == FULL_OCC))
        else $error("full status below capacity");

endmodule

bind stable_priority_queue spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_popped_item     (m_popped_item),
    .m_popped_priority (m_popped_priority),
    .m_occupancy       (m_occupancy)
);
